// ===== hw/rtl/hkr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hkr_pkg
// Types, keycode constants and the usage-to-keycode ROM for the keyboard
// report decoder.
// ----------------------------------------------------------------------------
package hkr_pkg;

    // Held-usage list and report geometry
    localparam int HELD_KEY_SLOTS = 4;
    localparam int HELD_IDX_W     = $clog2(HELD_KEY_SLOTS);
    localparam int HELD_CNT_W     = $clog2(HELD_KEY_SLOTS + 1);
    localparam int REPORT_SLOTS   = 4;

    // Event kinds
    localparam logic [1:0] KIND_PLAIN   = 2'd0;
    localparam logic [1:0] KIND_SHIFT   = 2'd1;
    localparam logic [1:0] KIND_CTRL    = 2'd2;
    localparam logic [1:0] KIND_LITERAL = 2'd3;

    // Keycodes with special handling
    localparam logic [7:0] KC_ENTER     = 8'h1C;
    localparam logic [7:0] KC_CAPS_LOCK = 8'h3A;
    localparam logic [7:0] KC_BACKSPACE = 8'h0E;
    localparam logic [7:0] KC_TAB       = 8'h0F;
    localparam logic [7:0] KC_PAUSE     = 8'h77;

    // Literal character codes
    localparam logic [7:0] CH_CR  = 8'd13;
    localparam logic [7:0] CH_BS  = 8'd8;
    localparam logic [7:0] CH_TAB = 8'd9;

    // Modifier byte values that act
    localparam logic [7:0] MOD_LSHIFT = 8'h02;
    localparam logic [7:0] MOD_RSHIFT = 8'h20;
    localparam logic [7:0] MOD_LCTRL  = 8'h01;
    localparam logic [7:0] MOD_RCTRL  = 8'h10;

    // One keyboard report
    typedef struct packed {
        logic [7:0] modifier_byte;
        logic [7:0] key_slot_0;
        logic [7:0] key_slot_1;
        logic [7:0] key_slot_2;
        logic [7:0] key_slot_3;
    } t_report;

    // One key event
    typedef struct packed {
        logic [7:0] code_value;
        logic [1:0] code_kind;
        logic       last_of_report;
    } t_event;

    // Decoder result for one report: events per slot and next state
    typedef struct packed {
        logic [REPORT_SLOTS-1:0]            ev_mask;
        logic [REPORT_SLOTS-1:0][7:0]       ev_value;
        logic [REPORT_SLOTS-1:0][1:0]       ev_kind;
        logic [HELD_KEY_SLOTS-1:0][7:0]     held_keys;
        logic [HELD_CNT_W-1:0]              held_count;
        logic                               caps_lock_on;
    } t_decode;

    // Usage-to-keycode ROM
    localparam logic [7:0] USAGE_ROM [256] = '{
          8'd0,   8'd0,   8'd0,   8'd0,  8'd30,  8'd48,  8'd46,  8'd32,  8'd18,  8'd33,
         8'd34,  8'd35,  8'd23,  8'd36,  8'd37,  8'd38,  8'd50,  8'd49,  8'd24,  8'd25,
         8'd16,  8'd19,  8'd31,  8'd20,  8'd22,  8'd47,  8'd17,  8'd45,  8'd21,  8'd44,
          8'd2,   8'd3,   8'd4,   8'd5,   8'd6,   8'd7,   8'd8,   8'd9,  8'd10,  8'd11,
         8'd28,   8'd1,  8'd14,  8'd15,  8'd57,  8'd12,  8'd13,  8'd26,  8'd27,  8'd43,
         8'd84,  8'd39,  8'd40,  8'd41,  8'd51,  8'd52,  8'd53,  8'd58,  8'd59,  8'd60,
         8'd61,  8'd62,  8'd63,  8'd64,  8'd65,  8'd66,  8'd67,  8'd68,  8'd87,  8'd88,
         8'd99,  8'd70, 8'd119, 8'd110, 8'd102, 8'd104, 8'd111, 8'd107, 8'd109, 8'd106,
        8'd105, 8'd108, 8'd103,  8'd69,  8'd98,  8'd55,  8'd74,  8'd78,  8'd96,  8'd79,
         8'd80,  8'd81,  8'd75,  8'd76,  8'd77,  8'd71,  8'd72,  8'd73,  8'd82,  8'd83,
         8'd86, 8'd127, 8'd116, 8'd117,  8'd85,  8'd89,  8'd90,  8'd91,  8'd92,  8'd93,
         8'd94,  8'd95, 8'd120, 8'd121, 8'd122, 8'd123, 8'd134, 8'd138, 8'd130, 8'd132,
        8'd128, 8'd129, 8'd131, 8'd137, 8'd133, 8'd135, 8'd136, 8'd113, 8'd115, 8'd114,
          8'd0,   8'd0,   8'd0, 8'd124,   8'd0, 8'd181, 8'd182, 8'd183, 8'd184, 8'd185,
        8'd186, 8'd187, 8'd188, 8'd189, 8'd190, 8'd191, 8'd192, 8'd193, 8'd194, 8'd195,
        8'd196, 8'd197, 8'd198,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
          8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
          8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
          8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
          8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
          8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
          8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
          8'd0,   8'd0,   8'd0,   8'd0,  8'd29,  8'd42,  8'd56, 8'd125,  8'd97,  8'd54,
        8'd100, 8'd126, 8'd164, 8'd166, 8'd165, 8'd163, 8'd161, 8'd115, 8'd114, 8'd113,
        8'd150, 8'd158, 8'd159, 8'd128, 8'd136, 8'd177, 8'd178, 8'd176, 8'd142, 8'd152,
        8'd173, 8'd140,   8'd0,   8'd0,   8'd0,   8'd0
    };

endpackage
`default_nettype wire

// ===== hw/rtl/hkr_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hkr_decode
// Combinational decode of one report: releases held usages that are gone,
// adds new ones, and works out up to one key event per usage slot.
// ----------------------------------------------------------------------------
module hkr_decode (
    input  wire hkr_pkg::t_report                                   i_report,
    input  wire logic [hkr_pkg::HELD_KEY_SLOTS-1:0][7:0]            i_held_keys,
    input  wire logic [hkr_pkg::HELD_CNT_W-1:0]                     i_held_count,
    input  wire logic                                               i_caps_lock_on,
    output hkr_pkg::t_decode                                        o_dec
);

    always_comb begin
        logic [hkr_pkg::REPORT_SLOTS-1:0][7:0]   slot;
        logic [hkr_pkg::HELD_KEY_SLOTS-1:0][7:0] h;
        logic [hkr_pkg::HELD_CNT_W-1:0]          c;
        logic                                    present;
        logic                                    active;
        logic                                    found;
        logic                                    caps;
        logic [7:0]                              code;
        logic [7:0]                              spec;

        slot[0] = i_report.key_slot_0;
        slot[1] = i_report.key_slot_1;
        slot[2] = i_report.key_slot_2;
        slot[3] = i_report.key_slot_3;

        o_dec = '0;

        // Release: keep held usages seen in any slot, packed to the front.
        // Only list membership and count matter downstream, so order is free.
        h = i_held_keys;
        c = '0;
        for (int k = 0; k < hkr_pkg::HELD_KEY_SLOTS; k++) begin
            present = 1'b0;
            for (int j = 0; j < hkr_pkg::REPORT_SLOTS; j++) begin
                if (i_held_keys[k] == slot[j]) begin
                    present = 1'b1;
                end
            end
            if ((hkr_pkg::HELD_CNT_W'(k) < i_held_count) && present) begin
                h[c[hkr_pkg::HELD_IDX_W-1:0]] = i_held_keys[k];
                c = c + 1'b1;
            end
        end

        // Press: walk slots up to the first empty one
        active = 1'b1;
        caps   = i_caps_lock_on;
        for (int i = 0; i < hkr_pkg::REPORT_SLOTS; i++) begin
            if (slot[i] == 8'd0) begin
                active = 1'b0;
            end
            found = 1'b0;
            for (int k = 0; k < hkr_pkg::HELD_KEY_SLOTS; k++) begin
                if ((hkr_pkg::HELD_CNT_W'(k) < c) && (h[k] == slot[i])) begin
                    found = 1'b1;
                end
            end
            code = hkr_pkg::USAGE_ROM[slot[i]];
            spec = (i == 0) ? i_report.modifier_byte : 8'd0;

            if (active && !found) begin
                // Add to the held list while there is room
                if (c < hkr_pkg::HELD_CNT_W'(hkr_pkg::HELD_KEY_SLOTS)) begin
                    h[c[hkr_pkg::HELD_IDX_W-1:0]] = slot[i];
                    c = c + 1'b1;
                end
                if (code != 8'd0) begin
                    o_dec.ev_value[i] = code;
                    if (spec != 8'd0) begin
                        // Only an exact shift or ctrl value sends the key
                        if ((spec == hkr_pkg::MOD_LSHIFT) || (spec == hkr_pkg::MOD_RSHIFT)) begin
                            o_dec.ev_mask[i] = 1'b1;
                            o_dec.ev_kind[i] = hkr_pkg::KIND_SHIFT;
                        end else if ((spec == hkr_pkg::MOD_LCTRL) ||
                                     (spec == hkr_pkg::MOD_RCTRL)) begin
                            o_dec.ev_mask[i] = 1'b1;
                            o_dec.ev_kind[i] = hkr_pkg::KIND_CTRL;
                        end
                    end else begin
                        case (code)
                            hkr_pkg::KC_ENTER: begin
                                o_dec.ev_mask[i]  = 1'b1;
                                o_dec.ev_value[i] = hkr_pkg::CH_CR;
                                o_dec.ev_kind[i]  = hkr_pkg::KIND_LITERAL;
                            end
                            hkr_pkg::KC_CAPS_LOCK: begin
                                caps = !caps;
                            end
                            hkr_pkg::KC_BACKSPACE: begin
                                o_dec.ev_mask[i]  = 1'b1;
                                o_dec.ev_value[i] = hkr_pkg::CH_BS;
                                o_dec.ev_kind[i]  = hkr_pkg::KIND_LITERAL;
                            end
                            hkr_pkg::KC_TAB: begin
                                o_dec.ev_mask[i]  = 1'b1;
                                o_dec.ev_value[i] = hkr_pkg::CH_TAB;
                                o_dec.ev_kind[i]  = hkr_pkg::KIND_LITERAL;
                            end
                            hkr_pkg::KC_PAUSE: begin
                                // ignored
                            end
                            default: begin
                                o_dec.ev_mask[i] = 1'b1;
                                o_dec.ev_kind[i] = caps ? hkr_pkg::KIND_SHIFT
                                                        : hkr_pkg::KIND_PLAIN;
                            end
                        endcase
                    end
                end
            end
        end

        o_dec.held_keys    = h;
        o_dec.held_count   = c;
        o_dec.caps_lock_on = caps;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/hkr_event_buf.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hkr_event_buf
// Holds the events of one report and sends them one per transfer, in slot
// order, marking the final one.
// ----------------------------------------------------------------------------
module hkr_event_buf (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  wire logic                                       i_load,
    input  wire logic [hkr_pkg::REPORT_SLOTS-1:0]           i_mask,
    input  wire logic [hkr_pkg::REPORT_SLOTS-1:0][7:0]      i_value,
    input  wire logic [hkr_pkg::REPORT_SLOTS-1:0][1:0]      i_kind,
    output logic                                            o_can_load,
    output logic                                            o_valid,
    input  wire logic                                       i_ready,
    output hkr_pkg::t_event                                 o_event
);

    logic [hkr_pkg::REPORT_SLOTS-1:0]      r_mask;
    logic [hkr_pkg::REPORT_SLOTS-1:0]      n_mask;
    logic [hkr_pkg::REPORT_SLOTS-1:0][7:0] r_value;
    logic [hkr_pkg::REPORT_SLOTS-1:0][1:0] r_kind;
    logic [hkr_pkg::REPORT_SLOTS-1:0]      low_bit;
    logic                                  pop;

    // Lowest pending slot
    always_comb begin
        low_bit = '0;
        for (int i = hkr_pkg::REPORT_SLOTS - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                low_bit    = '0;
                low_bit[i] = 1'b1;
            end
        end
    end

    assign o_valid = |r_mask;
    assign pop     = o_valid && i_ready;

    // Room for a new report once the last pending event goes out
    assign o_can_load = ((r_mask & ~low_bit) == '0) && (!o_valid || i_ready);

    // Output mux
    always_comb begin
        o_event = '0;
        for (int i = 0; i < hkr_pkg::REPORT_SLOTS; i++) begin
            if (low_bit[i]) begin
                o_event.code_value = r_value[i];
                o_event.code_kind  = r_kind[i];
            end
        end
        o_event.last_of_report = ((r_mask & ~low_bit) == '0);
    end

    always_comb begin
        n_mask = r_mask;
        if (pop) begin
            n_mask = r_mask & ~low_bit;
        end
        if (i_load) begin
            n_mask = i_mask;
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else begin
            r_mask <= n_mask;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_value <= i_value;
            r_kind  <= i_kind;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/hid_keyboard_report_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hid_keyboard_report_decoder
// Boot-keyboard report decoder: tracks held usages and emits key events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_report) takes one report
//   per transfer: modifier byte and four usage bytes.
//   Output channel (o_out_valid / i_out_ready / o_out_event) gives zero to
//   four key events per report, in slot order; last_of_report marks the
//   final event of a report. A report with no events gives no transfer.
//   A report is registered on acceptance and decoded from that register;
//   once the event buffer can load, held list and caps lock update and its
//   events load into the event buffer, which offers the first event.
//   Events leave one per cycle while the receiver is ready; the event
//   buffer sets the rate.
//   The next report loads as the previous report's last event goes out.
//   When the receiver stalls, the event buffer holds, then the input
//   register fills and o_in_ready drops.
//   Reset (synchronous, active low) empties the buffers, clears the held
//   count and turns caps lock off.
// ----------------------------------------------------------------------------
module hid_keyboard_report_decoder (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire hkr_pkg::t_report   i_in_report,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output hkr_pkg::t_event         o_out_event
);

    logic                                        r_in_valid;
    logic                                        n_in_valid;
    hkr_pkg::t_report                            r_in;
    logic [hkr_pkg::HELD_KEY_SLOTS-1:0][7:0]     r_held_keys;
    logic [hkr_pkg::HELD_CNT_W-1:0]              r_held_count;
    logic                                        r_caps_lock_on;
    hkr_pkg::t_decode                            dec;
    logic                                        can_load;
    logic                                        load;
    logic                                        in_xfer;

    // Input register handshake
    assign load       = r_in_valid && can_load;
    assign o_in_ready = !r_in_valid || load;
    assign in_xfer    = i_in_valid && o_in_ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (load) begin
            n_in_valid = 1'b0;
        end
        if (in_xfer) begin
            n_in_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= i_in_report;
        end
    end

    // Report decode
    hkr_decode u_decode (
        .i_report       (r_in),
        .i_held_keys    (r_held_keys),
        .i_held_count   (r_held_count),
        .i_caps_lock_on (r_caps_lock_on),
        .o_dec          (dec)
    );

    // Keyboard state, updated when a report is consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_count   <= '0;
            r_caps_lock_on <= 1'b0;
        end else if (load) begin
            r_held_count   <= dec.held_count;
            r_caps_lock_on <= dec.caps_lock_on;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_held_keys <= dec.held_keys;
        end
    end

    // Event buffer
    hkr_event_buf u_event_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_mask     (dec.ev_mask),
        .i_value    (dec.ev_value),
        .i_kind     (dec.ev_kind),
        .o_can_load (can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_event    (o_out_event)
    );

endmodule
`default_nettype wire

// ===== tb/sv/hkr_event_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkr_event_checker
// Watches both channels of the keyboard report decoder. Each accepted report
// runs through a local model of the held-usage list and the caps lock flag,
// and the key events it should cause are queued. Each event transfer on the
// output is compared field by field with the oldest queued event.
// ----------------------------------------------------------------------------
module hkr_event_checker (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_in_ready,
    input  wire hkr_pkg::t_report i_in_report,
    input  wire logic             i_out_valid,
    input  wire logic             i_out_ready,
    input  wire hkr_pkg::t_event  i_out_event,
    output int                    o_fail_count,
    output int                    o_pending
);
    import hkr_pkg::*;

    localparam int REPORT_KEYS = 4;
    localparam int HELD_DEPTH  = HELD_KEY_SLOTS;

    // Usage to keycode translation, kept independent of the design's copy
    localparam logic [7:0] KEYCODE_OF_USAGE [256] = '{
          8'd0,   8'd0,   8'd0,   8'd0,  8'd30,  8'd48,  8'd46,  8'd32,  8'd18,  8'd33,
         8'd34,  8'd35,  8'd23,  8'd36,  8'd37,  8'd38,  8'd50,  8'd49,  8'd24,  8'd25,
         8'd16,  8'd19,  8'd31,  8'd20,  8'd22,  8'd47,  8'd17,  8'd45,  8'd21,  8'd44,
          8'd2,   8'd3,   8'd4,   8'd5,   8'd6,   8'd7,   8'd8,   8'd9,  8'd10,  8'd11,
         8'd28,   8'd1,  8'd14,  8'd15,  8'd57,  8'd12,  8'd13,  8'd26,  8'd27,  8'd43,
         8'd84,  8'd39,  8'd40,  8'd41,  8'd51,  8'd52,  8'd53,  8'd58,  8'd59,  8'd60,
         8'd61,  8'd62,  8'd63,  8'd64,  8'd65,  8'd66,  8'd67,  8'd68,  8'd87,  8'd88,
         8'd99,  8'd70, 8'd119, 8'd110, 8'd102, 8'd104, 8'd111, 8'd107, 8'd109, 8'd106,
        8'd105, 8'd108, 8'd103,  8'd69,  8'd98,  8'd55,  8'd74,  8'd78,  8'd96,  8'd79,
         8'd80,  8'd81,  8'd75,  8'd76,  8'd77,  8'd71,  8'd72,  8'd73,  8'd82,  8'd83,
         8'd86, 8'd127, 8'd116, 8'd117,  8'd85,  8'd89,  8'd90,  8'd91,  8'd92,  8'd93,
         8'd94,  8'd95, 8'd120, 8'd121, 8'd122, 8'd123, 8'd134, 8'd138, 8'd130, 8'd132,
        8'd128, 8'd129, 8'd131, 8'd137, 8'd133, 8'd135, 8'd136, 8'd113, 8'd115, 8'd114,
          8'd0,   8'd0,   8'd0, 8'd124,   8'd0, 8'd181, 8'd182, 8'd183, 8'd184, 8'd185,
        8'd186, 8'd187, 8'd188, 8'd189, 8'd190, 8'd191, 8'd192, 8'd193, 8'd194, 8'd195,
        8'd196, 8'd197, 8'd198,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
          8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
          8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
          8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
          8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
          8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
          8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
          8'd0,   8'd0,   8'd0,   8'd0,  8'd29,  8'd42,  8'd56, 8'd125,  8'd97,  8'd54,
        8'd100, 8'd126, 8'd164, 8'd166, 8'd165, 8'd163, 8'd161, 8'd115, 8'd114, 8'd113,
        8'd150, 8'd158, 8'd159, 8'd128, 8'd136, 8'd177, 8'd178, 8'd176, 8'd142, 8'd152,
        8'd173, 8'd140,   8'd0,   8'd0,   8'd0,   8'd0
    };

    // Model state: held usages, their count, caps lock
    logic [7:0]      held_usage [HELD_DEPTH];
    int              held_total;
    bit              caps_on;
    hkr_pkg::t_event expected_events [$];
    int              mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    // One line per mismatch, and count it
    task automatic log_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // Release missing usages, press new ones, queue the events they cause
    task automatic predict_report(input hkr_pkg::t_report rpt);
        logic [7:0]      slot [REPORT_KEYS];
        hkr_pkg::t_event ev [REPORT_KEYS];
        logic [7:0]      usage;
        logic [7:0]      keycode;
        logic [7:0]      spec;
        logic [7:0]      value;
        logic [1:0]      kind;
        bit              present;
        bit              found;
        bit              scanning;
        bit              fire;
        int              n;
        int              i;
        int              j;
        slot[0] = rpt.key_slot_0;
        slot[1] = rpt.key_slot_1;
        slot[2] = rpt.key_slot_2;
        slot[3] = rpt.key_slot_3;

        // release: compared against all slots, also those past a zero
        i = 0;
        while (i < held_total) begin
            present = 1'b0;
            for (j = 0; j < REPORT_KEYS; j++) begin
                if (held_usage[i] == slot[j]) present = 1'b1;
            end
            if (present) begin
                i++;
            end else begin
                held_total--;
                held_usage[i] = held_usage[held_total];
            end
        end

        // press: slots are read up to the first zero
        n = 0;
        scanning = 1'b1;
        for (i = 0; i < REPORT_KEYS; i++) begin
            usage = slot[i];
            if (usage == 8'd0) scanning = 1'b0;
            found = 1'b0;
            for (j = 0; j < held_total; j++) begin
                if (held_usage[j] == usage) found = 1'b1;
            end
            if (scanning && !found) begin
                if (held_total < HELD_DEPTH) begin
                    held_usage[held_total] = usage;
                    held_total++;
                end
                keycode = KEYCODE_OF_USAGE[usage];
                spec    = (i == 0) ? rpt.modifier_byte : 8'd0;
                fire    = 1'b0;
                value   = keycode;
                kind    = KIND_PLAIN;
                if (keycode != 8'd0 && spec != 8'd0) begin
                    // only exact shift or ctrl values act; anything else is dropped
                    if (spec == MOD_LSHIFT || spec == MOD_RSHIFT) begin
                        fire = 1'b1;
                        kind = KIND_SHIFT;
                    end else if (spec == MOD_LCTRL || spec == MOD_RCTRL) begin
                        fire = 1'b1;
                        kind = KIND_CTRL;
                    end
                end else if (keycode != 8'd0) begin
                    case (keycode)
                        KC_ENTER: begin
                            fire  = 1'b1;
                            value = CH_CR;
                            kind  = KIND_LITERAL;
                        end
                        KC_BACKSPACE: begin
                            fire  = 1'b1;
                            value = CH_BS;
                            kind  = KIND_LITERAL;
                        end
                        KC_TAB: begin
                            fire  = 1'b1;
                            value = CH_TAB;
                            kind  = KIND_LITERAL;
                        end
                        KC_CAPS_LOCK: begin
                            caps_on = !caps_on;
                        end
                        KC_PAUSE: begin
                        end
                        default: begin
                            fire = 1'b1;
                            kind = caps_on ? KIND_SHIFT : KIND_PLAIN;
                        end
                    endcase
                end
                if (fire) begin
                    ev[n] = '{code_value: value, code_kind: kind, last_of_report: 1'b0};
                    n++;
                end
            end
        end

        for (i = 0; i < n; i++) begin
            ev[i].last_of_report = (i == n - 1);
            expected_events.push_back(ev[i]);
        end
    endtask

    // Sample both channels at the rising edge
    always @(posedge i_clk) begin : watch
        hkr_pkg::t_event want;
        if (!i_rst_n) begin
            held_total = 0;
            caps_on    = 1'b0;
            for (int k = 0; k < HELD_DEPTH; k++) held_usage[k] = 8'd0;
            expected_events.delete();
        end else begin
            // output first: an event never belongs to a report taken this cycle
            if (i_out_valid && i_out_ready) begin
                if (expected_events.size() == 0) begin
                    log_mismatch($sformatf("unexpected event value %0d kind %0d last %0b",
                        i_out_event.code_value, i_out_event.code_kind,
                        i_out_event.last_of_report));
                end else begin
                    want = expected_events.pop_front();
                    if (i_out_event.code_value !== want.code_value)
                        log_mismatch($sformatf("code_value got %0d want %0d",
                            i_out_event.code_value, want.code_value));
                    if (i_out_event.code_kind !== want.code_kind)
                        log_mismatch($sformatf("code_kind got %0d want %0d (value %0d)",
                            i_out_event.code_kind, want.code_kind, want.code_value));
                    if (i_out_event.last_of_report !== want.last_of_report)
                        log_mismatch($sformatf("last_of_report got %0b want %0b (value %0d)",
                            i_out_event.last_of_report, want.last_of_report,
                            want.code_value));
                end
            end
            if (i_in_valid && i_in_ready) predict_report(i_in_report);
        end
        o_pending <= expected_events.size();
    end

endmodule

// ===== tb/sv/hid_keyboard_report_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hid_keyboard_report_decoder_tb
// Drives keyboard reports into the decoder and pulls key events out with
// random gaps and stalls on both sides. A short directed run covers the
// modifier values, the literal keys, caps lock, pause, unmapped usages and
// release ordering; random key rolls with some noise follow. Checking is
// done by the event checker beside the design.
// ----------------------------------------------------------------------------
module hid_keyboard_report_decoder_tb;
    import hkr_pkg::*;

    localparam int RUN_LIMIT = 300000;
    localparam int MAX_WAIT  = 18;

    // Modifier values the package does not name
    localparam logic [7:0] MOD_LALT = 8'h04;
    localparam logic [7:0] MOD_RALT = 8'h40;
    localparam logic [7:0] MOD_NONE = 8'h00;

    // Usage codes with special meaning
    localparam logic [7:0] USAGE_NONE   = 8'h00;
    localparam logic [7:0] USAGE_A      = 8'h04;
    localparam logic [7:0] USAGE_ENTER  = 8'h28;
    localparam logic [7:0] USAGE_BKSP   = 8'h2A;
    localparam logic [7:0] USAGE_TAB    = 8'h2B;
    localparam logic [7:0] USAGE_CAPS   = 8'h39;
    localparam logic [7:0] USAGE_PAUSE  = 8'h48;
    localparam logic [7:0] USAGE_LCTRL  = 8'hE0;
    localparam logic [7:0] USAGE_RGUI   = 8'hE7;
    localparam logic [7:0] USAGE_ERRROLL = 8'h01;
    localparam logic [7:0] USAGE_TOP    = 8'hFF;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    hkr_pkg::t_report in_report;
    logic             out_valid;
    logic             out_ready;
    hkr_pkg::t_event  out_event;
    int               fail_count;
    int               pending_events;
    int               cycle_count = 0;
    bit               no_idle;
    logic [7:0]       prev_keys [4];

    always #4 clk = ~clk;

    always @(posedge clk) cycle_count <= cycle_count + 1;

    hid_keyboard_report_decoder DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_report (in_report),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_event (out_event)
    );

    hkr_event_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_report  (in_report),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_event  (out_event),
        .o_fail_count (fail_count),
        .o_pending    (pending_events)
    );

    // Idle cycles before a transfer; none during burst stretches
    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // One report transfer; entered and left at a falling edge
    task automatic send_report(input logic [7:0] modifier, input logic [7:0] k0,
                               input logic [7:0] k1, input logic [7:0] k2,
                               input logic [7:0] k3);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        in_report <= '{modifier_byte: modifier, key_slot_0: k0, key_slot_1: k1,
                       key_slot_2: k2, key_slot_3: k3};
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // Usage pool: mostly mapped keys, some specials, modifiers and the rest
    function automatic logic [7:0] draw_usage();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel <= 5) return 8'($urandom_range(USAGE_A, 8'h65));
        if (sel == 7) return 8'($urandom_range(USAGE_LCTRL, USAGE_RGUI));
        if (sel == 8) return 8'($urandom_range(8'h66, 8'hDF));
        if (sel == 9) return 8'($urandom_range(0, 255));
        case ($urandom_range(0, 4))
            0:       return USAGE_ENTER;
            1:       return USAGE_BKSP;
            2:       return USAGE_TAB;
            3:       return USAGE_CAPS;
            default: return USAGE_PAUSE;
        endcase
    endfunction

    // Key roll that keeps some of the previous keys; one in five is noise
    task automatic send_random_report();
        logic [7:0] keys [4];
        logic [7:0] modifier;
        int         nkeys;
        if ($urandom_range(0, 99) < 20) begin
            modifier = 8'($urandom_range(0, 255));
            for (int k = 0; k < 4; k++) keys[k] = 8'($urandom_range(0, 255));
        end else begin
            case ($urandom_range(0, 11))
                0, 1, 2, 3, 4: modifier = MOD_NONE;
                5:             modifier = MOD_LSHIFT;
                6:             modifier = MOD_RSHIFT;
                7:             modifier = MOD_LCTRL;
                8:             modifier = MOD_RCTRL;
                9:             modifier = MOD_LALT;
                10:            modifier = MOD_RALT;
                default:       modifier = 8'($urandom_range(0, 255));
            endcase
            nkeys = $urandom_range(0, 4);
            for (int k = 0; k < 4; k++) begin
                if (k >= nkeys) begin
                    keys[k] = USAGE_NONE;
                end else begin
                    keys[k] = prev_keys[$urandom_range(0, 3)];
                    if (keys[k] == USAGE_NONE || $urandom_range(0, 1) == 0)
                        keys[k] = draw_usage();
                end
            end
        end
        prev_keys = keys;
        send_report(modifier, keys[0], keys[1], keys[2], keys[3]);
    endtask

    // Hold off input until every queued event has been seen
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending_events != 0);
    endtask

    // Event sink with random stalls
    initial begin : sink
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    // Run limit
    initial begin
        wait (cycle_count >= RUN_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // Stimulus and verdict
    initial begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_report = '0;
        no_idle   = 1'b0;
        for (int k = 0; k < 4; k++) prev_keys[k] = USAGE_NONE;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // directed: modifiers, literals, caps lock, pause, unmapped, release
        send_report(MOD_NONE, 8'h00, 8'h00, 8'h00, 8'h00);
        send_report(MOD_NONE, USAGE_A, 8'h00, 8'h00, 8'h00);
        send_report(MOD_NONE, USAGE_A, 8'h00, 8'h00, 8'h00);
        send_report(MOD_LSHIFT, 8'h05, 8'h00, 8'h00, 8'h00);
        send_report(MOD_RSHIFT, 8'h06, 8'h00, 8'h00, 8'h00);
        send_report(MOD_LCTRL, 8'h07, 8'h00, 8'h00, 8'h00);
        send_report(MOD_RCTRL, 8'h08, 8'h00, 8'h00, 8'h00);
        send_report(MOD_LALT, 8'h09, 8'h00, 8'h00, 8'h00);
        send_report(MOD_RALT, 8'h0A, 8'h00, 8'h00, 8'h00);
        send_report(8'hFF, 8'h0B, 8'h00, 8'h00, 8'h00);
        // modifier only counts for the first slot
        send_report(MOD_LSHIFT, 8'h0C, 8'h0D, 8'h0E, 8'h0F);
        send_report(MOD_NONE, USAGE_ENTER, USAGE_BKSP, USAGE_TAB, USAGE_PAUSE);
        send_report(MOD_LSHIFT, USAGE_ENTER, 8'h00, 8'h00, 8'h00);
        send_report(MOD_NONE, USAGE_CAPS, 8'h00, 8'h00, 8'h00);
        send_report(MOD_NONE, USAGE_CAPS, USAGE_A, 8'h00, 8'h00);
        send_report(MOD_NONE, 8'h10, 8'h00, 8'h00, 8'h00);
        send_report(MOD_NONE, USAGE_CAPS, 8'h00, 8'h00, 8'h00);
        // unmapped usages are held but silent
        send_report(MOD_NONE, USAGE_ERRROLL, USAGE_TOP, 8'h11, 8'h00);
        // a held key past a zero slot stays held
        send_report(MOD_NONE, 8'h12, 8'h13, 8'h00, 8'h00);
        send_report(MOD_NONE, 8'h12, 8'h00, 8'h13, 8'h00);
        send_report(MOD_NONE, 8'h12, 8'h13, 8'h14, 8'h00);
        send_report(MOD_NONE, USAGE_LCTRL, USAGE_RGUI, 8'h00, 8'h00);
        send_report(MOD_NONE, 8'h15, 8'h15, 8'h00, 8'h00);
        // swap-in of the last entry on release
        send_report(MOD_NONE, 8'h16, 8'h17, 8'h18, 8'h19);
        send_report(MOD_NONE, 8'h19, 8'h17, 8'h00, 8'h00);
        send_report(MOD_NONE, 8'h19, 8'h17, 8'h1A, 8'h00);
        send_report(MOD_NONE, 8'h00, 8'h00, 8'h00, 8'h00);

        // random rolls with idling
        repeat (25) send_random_report();
        // back-to-back stretch
        no_idle = 1'b1;
        repeat (25) send_random_report();
        no_idle = 1'b0;
        wait_drained();
        repeat (25) send_random_report();

        wait_drained();
        repeat (16) @(negedge clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/hkr_pkg.sv
hw/rtl/hkr_decode.sv
hw/rtl/hkr_event_buf.sv
hw/rtl/hid_keyboard_report_decoder.sv
tb/sv/hkr_event_checker.sv
tb/sv/hid_keyboard_report_decoder_tb.sv
